// ===== src/accelerating_blink_envelope_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the accelerating blink envelope unit
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ACCELERATING_BLINK_ENVELOPE_UNIT_MACROS_SVH
`define ACCELERATING_BLINK_ENVELOPE_UNIT_MACROS_SVH

// same-cycle implication
`define ABE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ABE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/abe_pkg.sv =====
// ----------------------------------------------------------------------------
// abe_pkg
// Shared types and constants of the accelerating blink envelope unit.
// ----------------------------------------------------------------------------
package abe_pkg;

	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int EL_W            = 16;
	localparam int LVL_INT_W       = 16;
	localparam int NOW_PORT_W      = 32;
	localparam int COEFF_FRAC_BITS = 8;

	// ramp speed: magnitude saturated at 2^42, stored signed
	localparam int SPD_CAP_EXP = 42;
	localparam int SMAG_W      = SPD_CAP_EXP + 1;
	localparam int SPD_W       = SMAG_W + 1;
	localparam int STEP_W      = SMAG_W + EL_W;
	localparam int MUL_STEPS   = EL_W;

	localparam logic [SMAG_W-1:0] SPD_CAP = SMAG_W'(1) << SPD_CAP_EXP;

	localparam logic [CFG_W-1:0] RST_START_INTERVAL = 16'd1000;
	localparam logic [CFG_W-1:0] RST_FLOOR_INTERVAL = 16'd100;
	localparam logic [CFG_W-1:0] RST_INTERVAL_STEP  = 16'd100;
	localparam logic [CFG_W-1:0] RST_LEVEL_LOW      = 16'd0;
	localparam logic [CFG_W-1:0] RST_LEVEL_HIGH     = 16'd65535;
	localparam logic [CFG_W-1:0] RST_RAMP_COEFF     = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_INTERVAL = 3'd0,
		REG_FLOOR_INTERVAL = 3'd1,
		REG_INTERVAL_STEP  = 3'd2,
		REG_LEVEL_LOW      = 3'd3,
		REG_LEVEL_HIGH     = 3'd4,
		REG_RAMP_COEFF     = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_RESTART = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		logic restart;
		logic mul_step;
		logic apply;
		logic div_step;
		logic set_speed;
		logic push;
	} abe_cmd_t;

	typedef struct packed {
		logic switch_due;
	} abe_sts_t;

endpackage

// ===== src/abe_ctrl.sv =====
// ----------------------------------------------------------------------------
// abe_ctrl
// Sequencer: multiply, level update, divide, speed write, result beat.
// ----------------------------------------------------------------------------
module abe_ctrl import abe_pkg::*; #(
	parameter int DIV_STEPS = 40
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     operation,
	output logic     out_valid,
	input  logic     out_ready,
	input  abe_sts_t sts,
	output abe_cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS > MUL_STEPS ? DIV_STEPS : MUL_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_APPLY,
		S_DIV,
		S_SPEED,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               accept;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.start     = accept;
		cmd.restart   = accept && (op_t'(operation) == OP_RESTART);
		cmd.mul_step  = (state_q == S_MUL);
		cmd.apply     = (state_q == S_APPLY);
		cmd.div_step  = (state_q == S_DIV);
		cmd.set_speed = (state_q == S_SPEED);
		cmd.push      = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op_t'(operation) == OP_RESTART) begin
							state_q <= S_DIV;
							cnt_q   <= CNT_W'(DIV_STEPS - 1);
						end else begin
							state_q <= S_MUL;
							cnt_q   <= CNT_W'(MUL_STEPS - 1);
						end
					end
				end
				S_MUL: begin
					if (cnt_q == '0)
						state_q <= S_APPLY;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_APPLY: begin
					if (sts.switch_due) begin
						state_q <= S_DIV;
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_SPEED;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_SPEED: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.push)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/abe_datapath.sv =====
// ----------------------------------------------------------------------------
// abe_datapath
// Config registers, envelope state, shift-add multiplier, restoring divider.
// ----------------------------------------------------------------------------
module abe_datapath import abe_pkg::*; #(
	parameter int LEVEL_FRAC_BITS = 16,
	parameter int TIME_BITS       = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abe_cmd_t              cmd,
	output abe_sts_t              sts,
	input  logic [NOW_PORT_W-1:0] now_ms,
	input  logic [EL_W-1:0]       elapsed_ms,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic [LVL_INT_W-1:0]  level
);

	localparam int LVL_W = LVL_INT_W + LEVEL_FRAC_BITS;
	localparam int NUM_W = 2 * CFG_W + LEVEL_FRAC_BITS - COEFF_FRAC_BITS;
	localparam int NOW_W = (TIME_BITS < NOW_PORT_W) ? TIME_BITS : NOW_PORT_W;
	localparam int SW_W  = TIME_BITS + 1;
	localparam int Q_W   = (NUM_W > SMAG_W) ? NUM_W : SMAG_W;
	localparam int V_W   = STEP_W + 2;

	logic [CFG_W-1:0] start_int_q, floor_int_q, step_q, low_q, high_q, coeff_q;

	logic [LVL_W-1:0]        level_q;
	logic [CFG_W-1:0]        half_q;
	logic signed [SPD_W-1:0] speed_q;
	logic [SW_W-1:0]         next_sw_q;

	logic [NOW_W-1:0]     now_q;
	logic [EL_W-1:0]      el_q;
	logic [STEP_W-1:0]    prod_q;
	logic [NUM_W-1:0]     dq_q;
	logic [CFG_W-1:0]     rem_q;
	logic                 span_neg_q;
	logic                 dir_neg_q;
	logic [LVL_INT_W-1:0] level_out_q;

	logic                    span_neg;
	logic [CFG_W-1:0]        abs_span;
	logic [2*CFG_W-1:0]      scale;
	logic [NUM_W-1:0]        dividend;
	logic [SPD_W-1:0]        spd_abs;
	logic [SMAG_W-1:0]       spd_mag;
	logic [CFG_W-1:0]        dvs;
	logic [CFG_W:0]          trial;
	logic                    ge;
	logic [CFG_W:0]          trial_sub;
	logic [CFG_W-1:0]        rem_nxt;
	logic signed [V_W-1:0]   lvl_v, step_v, sum_v, hi_v, lo_v, clip_hi, clip_lo;
	logic signed [CFG_W:0]   half_diff, floor_s;
	logic [CFG_W-1:0]        half_shrunk;
	logic [Q_W-1:0]          q_ext;
	logic [SMAG_W-1:0]       new_smag;
	logic signed [SPD_W-1:0] spd_pos, new_speed;

	// speed numerator: coeff * |high - low|, aligned to the level's fraction
	assign span_neg = low_q > high_q;
	assign abs_span = span_neg ? (low_q - high_q) : (high_q - low_q);
	assign scale    = coeff_q * abs_span;
	assign dividend = NUM_W'(scale) << (LEVEL_FRAC_BITS - COEFF_FRAC_BITS);

	assign spd_abs = speed_q[SPD_W-1] ? SPD_W'(-speed_q) : SPD_W'(speed_q);
	assign spd_mag = spd_abs[SMAG_W-1:0];

	// restoring divider, one quotient bit per cycle
	assign dvs       = (half_q == '0) ? CFG_W'(1) : half_q;
	assign trial     = {rem_q, dq_q[NUM_W-1]};
	assign ge        = trial >= {1'b0, dvs};
	assign trial_sub = trial - {1'b0, dvs};
	assign rem_nxt   = ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];

	// level step and clamp: min with high first, then max with low
	assign lvl_v   = $signed(V_W'(level_q));
	assign step_v  = $signed(V_W'(prod_q));
	assign sum_v   = speed_q[SPD_W-1] ? (lvl_v - step_v) : (lvl_v + step_v);
	assign hi_v    = $signed(V_W'({high_q, {LEVEL_FRAC_BITS{1'b0}}}));
	assign lo_v    = $signed(V_W'({low_q, {LEVEL_FRAC_BITS{1'b0}}}));
	assign clip_hi = (sum_v > hi_v) ? hi_v : sum_v;
	assign clip_lo = (clip_hi < lo_v) ? lo_v : clip_hi;

	// half-period shrink, floored
	assign half_diff   = $signed({1'b0, half_q}) - $signed({1'b0, step_q});
	assign floor_s     = $signed({1'b0, floor_int_q});
	assign half_shrunk = (half_q > floor_int_q)
		? ((half_diff < floor_s) ? floor_int_q : half_diff[CFG_W-1:0])
		: half_q;

	assign q_ext     = Q_W'(dq_q);
	assign new_smag  = (q_ext > Q_W'(SPD_CAP)) ? SPD_CAP : q_ext[SMAG_W-1:0];
	assign spd_pos   = $signed({1'b0, new_smag});
	assign new_speed = (span_neg_q ^ dir_neg_q) ? -spd_pos : spd_pos;

	assign sts.switch_due = SW_W'(now_q) >= next_sw_q;
	assign level          = level_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_int_q <= RST_START_INTERVAL;
			floor_int_q <= RST_FLOOR_INTERVAL;
			step_q      <= RST_INTERVAL_STEP;
			low_q       <= RST_LEVEL_LOW;
			high_q      <= RST_LEVEL_HIGH;
			coeff_q     <= RST_RAMP_COEFF;
			level_q     <= '0;
			half_q      <= RST_START_INTERVAL;
			speed_q     <= '0;
			next_sw_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_START_INTERVAL: start_int_q <= cfg_data;
					REG_FLOOR_INTERVAL: floor_int_q <= cfg_data;
					REG_INTERVAL_STEP:  step_q      <= cfg_data;
					REG_LEVEL_LOW:      low_q       <= cfg_data;
					REG_LEVEL_HIGH:     high_q      <= cfg_data;
					REG_RAMP_COEFF:     coeff_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.restart) begin
				level_q <= {high_q, {LEVEL_FRAC_BITS{1'b0}}};
				half_q  <= start_int_q;
			end
			if (cmd.apply) begin
				level_q <= clip_lo[LVL_W-1:0];
				if (sts.switch_due)
					half_q <= half_shrunk;
			end
			if (cmd.set_speed) begin
				speed_q   <= new_speed;
				next_sw_q <= SW_W'(now_q) + SW_W'(half_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			now_q      <= now_ms[NOW_W-1:0];
			el_q       <= elapsed_ms;
			prod_q     <= '0;
			dq_q       <= dividend;
			rem_q      <= '0;
			span_neg_q <= span_neg;
			if (cmd.restart)
				dir_neg_q <= 1'b1;
		end
		if (cmd.mul_step) begin
			// MSB-first shift-add over elapsed
			prod_q <= (prod_q << 1) + (el_q[EL_W-1] ? STEP_W'(spd_mag) : '0);
			el_q   <= el_q << 1;
		end
		if (cmd.apply && sts.switch_due)
			dir_neg_q <= !speed_q[SPD_W-1];
		if (cmd.div_step) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[NUM_W-2:0], ge};
		end
		if (cmd.push)
			level_out_q <= level_q[LVL_W-1 -: LVL_INT_W];
	end

endmodule

// ===== src/accelerating_blink_envelope_unit.sv =====
// ----------------------------------------------------------------------------
// accelerating_blink_envelope_unit
// Blink envelope whose half-period shrinks at every direction switch, down to a floor.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | operation, now_ms, elapsed_ms
//  out      | out_valid / out_ready| level
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
//  Advance without switch: 16-step shift-add multiply over elapsed, level update.
//  Restart: restoring divider for the new speed, one quotient bit a cycle.
//  Advance with switch: both, multiply and level update, then the divider.
//  One item at a time; in_ready is low from accept until the result beat is
//  loaded into the output register, so a stalled out holds the next item.
//  Reset loads the config defaults and the idle envelope state.
// ----------------------------------------------------------------------------
`include "accelerating_blink_envelope_unit_macros.svh"

module accelerating_blink_envelope_unit import abe_pkg::*; #(
	parameter int LEVEL_FRAC_BITS = 16,
	parameter int TIME_BITS       = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [NOW_PORT_W-1:0] now_ms,
	input  logic [EL_W-1:0]       elapsed_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LVL_INT_W-1:0]  level,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int DIV_STEPS = 2 * CFG_W + LEVEL_FRAC_BITS - COEFF_FRAC_BITS;

	abe_cmd_t cmd;
	abe_sts_t sts;

	assign cfg_ready = 1'b1;

	abe_ctrl #(
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	abe_datapath #(
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
		.TIME_BITS       (TIME_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.now_ms     (now_ms),
		.elapsed_ms (elapsed_ms),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.level      (level)
	);

	`ABE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "accepted a beat but stayed ready")
	`ABE_ASSERT_IMPL(a_push_has_room, clk, arst_n, cmd.push, !out_valid || out_ready, "result overwrites a pending beat")
	`ABE_ASSERT_IMPL(a_one_phase, clk, arst_n, 1'b1, $onehot0({cmd.start, cmd.mul_step, cmd.apply, cmd.div_step, cmd.set_speed, cmd.push}), "more than one datapath phase at once")

endmodule

// ===== verif/accelerating_blink_envelope_unit_test.sv =====
// ----------------------------------------------------------------------------
// accelerating_blink_envelope_unit_test
// Self-checking bench for the blink envelope. A driver feeds restart and advance
// beats from a queue, a monitor checks every level against an in-bench model
// of the ramp, clamp and half-period shrink, across several register settings.
// ----------------------------------------------------------------------------
module accelerating_blink_envelope_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import abe_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int END_WAIT    = 80;
	localparam int MAX_REPORTS = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	typedef struct {
		op_t                   op;
		logic [NOW_PORT_W-1:0] now;
		logic [EL_W-1:0]       el;
	} env_beat_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic                  operation  = 1'b0;
	logic [NOW_PORT_W-1:0] now_ms     = '0;
	logic [EL_W-1:0]       elapsed_ms = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [LVL_INT_W-1:0]  level;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_W-1:0]      cfg_data   = '0;

	accelerating_blink_envelope_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.now_ms     (now_ms),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.level      (level),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// register shadows
	logic [CFG_W-1:0] start_iv = RST_START_INTERVAL;
	logic [CFG_W-1:0] floor_iv = RST_FLOOR_INTERVAL;
	logic [CFG_W-1:0] step_iv  = RST_INTERVAL_STEP;
	logic [CFG_W-1:0] lvl_lo   = RST_LEVEL_LOW;
	logic [CFG_W-1:0] lvl_hi   = RST_LEVEL_HIGH;
	logic [CFG_W-1:0] coeff    = RST_RAMP_COEFF;

	// envelope state: level Q16.16, signed speed per ms, switch time never wraps
	longint unsigned acc_q    = 0;
	longint          hp_q     = longint'(RST_START_INTERVAL);
	longint          spd_q    = 0;
	longint unsigned sw_due_q = 0;

	env_beat_t            pending_beats[$];
	logic [LVL_INT_W-1:0] level_expect[$];
	env_beat_t            next_beat;

	int idle_pct     = 32;
	int fail_count   = 0;
	int beat_count   = 0;
	int restarts     = 0;
	int switches     = 0;
	int reg_writes   = 0;
	int settings     = 1;
	int quiet_cycles = 0;

	function automatic longint ramp_rate(input bit upward);
		longint span, num, div, mag;
		span = longint'(lvl_hi) - longint'(lvl_lo);
		num  = longint'(coeff) * span * (64'sd1 <<< (FRAC_BITS - COEFF_FRAC_BITS));
		div  = (hp_q > 0) ? hp_q : 64'sd1;
		mag  = num / div;
		return upward ? mag : -mag;
	endfunction

	function automatic logic [LVL_INT_W-1:0] predict_level(input op_t op,
			input logic [NOW_PORT_W-1:0] now, input logic [EL_W-1:0] el);
		longint cap, sp, v, hi, lo, fl;
		logic [63:0] now_w;
		cap   = 64'sd1 <<< SPD_CAP_EXP;
		now_w = {32'b0, now};
		if (op == OP_RESTART) begin
			acc_q    = longint'(lvl_hi) <<< FRAC_BITS;
			hp_q     = longint'(start_iv);
			spd_q    = ramp_rate(1'b0);
			sw_due_q = now_w + hp_q;
		end else begin
			sp = spd_q;
			if (sp > cap)
				sp = cap;
			if (sp < -cap)
				sp = -cap;
			v  = longint'(acc_q) + sp * longint'(el);
			hi = longint'(lvl_hi) <<< FRAC_BITS;
			lo = longint'(lvl_lo) <<< FRAC_BITS;
			// low above high ends at low
			if (v > hi)
				v = hi;
			if (v < lo)
				v = lo;
			acc_q = v;
			if (now_w >= sw_due_q) begin
				fl = longint'(floor_iv);
				if (hp_q > fl) begin
					hp_q -= longint'(step_iv);
					if (hp_q < fl)
						hp_q = fl;
				end
				sw_due_q = now_w + hp_q;
				spd_q    = (spd_q < 0) ? ramp_rate(1'b1) : ramp_rate(1'b0);
				switches++;
			end
		end
		return LVL_INT_W'(acc_q >> FRAC_BITS);
	endfunction

	function automatic void flag_fail(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, what);
	endfunction

	// input side: present beats, predict on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				level_expect.push_back(predict_level(op_t'(operation), now_ms, elapsed_ms));
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_beat = pending_beats.pop_front();
					in_valid   <= 1'b1;
					operation  <= next_beat.op;
					now_ms     <= next_beat.now;
					elapsed_ms <= next_beat.el;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: random back-pressure, check each level beat
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (level_expect.size() == 0)
					flag_fail($sformatf("unexpected level beat %0d", level));
				else if (level !== level_expect[0])
					flag_fail($sformatf("level mismatch: expected %0d, got %0d",
						level_expect.pop_front(), level));
				else
					void'(level_expect.pop_front());
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_beat(input op_t op, input logic [NOW_PORT_W-1:0] now,
			input logic [EL_W-1:0] el);
		env_beat_t b;
		b.op  = op;
		b.now = now;
		b.el  = el;
		pending_beats.push_back(b);
		beat_count++;
		if (op == OP_RESTART)
			restarts++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_START_INTERVAL: start_iv = val;
			REG_FLOOR_INTERVAL: floor_iv = val;
			REG_INTERVAL_STEP:  step_iv  = val;
			REG_LEVEL_LOW:      lvl_lo   = val;
			REG_LEVEL_HIGH:     lvl_hi   = val;
			REG_RAMP_COEFF:     coeff    = val;
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] fl,
			input logic [CFG_W-1:0] stp, input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] cf);
		write_reg(REG_START_INTERVAL, st);
		write_reg(REG_FLOOR_INTERVAL, fl);
		write_reg(REG_INTERVAL_STEP, stp);
		write_reg(REG_LEVEL_LOW, lo);
		write_reg(REG_LEVEL_HIGH, hi);
		write_reg(REG_RAMP_COEFF, cf);
		settings++;
	endtask

	// restart followed by a run of mostly advances with consistent time stamps, with an occasional random beat
	task automatic queue_blink_runs(input int runs, input int max_el);
		logic [NOW_PORT_W-1:0] t;
		logic [EL_W-1:0]       el;
		int                    n;
		repeat (runs) begin
			t = $urandom();
			if ($urandom_range(5) == 0)
				t = 32'hFFFF_FFFF - $urandom_range(3000);
			push_beat(OP_RESTART, t, EL_W'($urandom()));
			n = $urandom_range(15, 45);
			repeat (n) begin
				case ($urandom_range(24))
					0: push_beat(op_t'($urandom_range(1)), $urandom(), EL_W'($urandom()));
					1: begin
						el = EL_W'($urandom());
						t  = t + el;
						push_beat(OP_ADVANCE, t, el);
					end
					default: begin
						el = EL_W'($urandom_range(max_el));
						t  = t + el;
						push_beat(OP_ADVANCE, t, el);
					end
				endcase
			end
		end
	endtask

	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || in_valid || level_expect.size() != 0);
	endtask

	initial begin
		logic [CFG_W-1:0] st, lo, hi;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		push_beat(OP_ADVANCE, 32'd0, 16'd0);
		push_beat(OP_ADVANCE, 32'd5, 16'd5);
		push_beat(OP_RESTART, 32'd0, 16'hFFFF);
		push_beat(OP_ADVANCE, 32'd0, 16'd0);
		push_beat(OP_ADVANCE, 32'd400, 16'd400);
		push_beat(OP_ADVANCE, 32'd999, 16'd599);
		push_beat(OP_ADVANCE, 32'd1000, 16'd1);
		push_beat(OP_ADVANCE, 32'd1000, 16'd0);
		push_beat(OP_ADVANCE, 32'd1900, 16'd900);
		push_beat(OP_ADVANCE, 32'd2000, 16'hFFFF);
		push_beat(OP_ADVANCE, 32'd3000, 16'hFFFF);
		push_beat(OP_ADVANCE, 32'hAAAA_AAAA, 16'hAAAA);
		push_beat(OP_ADVANCE, 32'h5555_5555, 16'h5555);
		// switch time beyond the time range: no switch until restart
		push_beat(OP_RESTART, 32'hFFFF_FFFF, 16'd0);
		push_beat(OP_ADVANCE, 32'hFFFF_FFFF, 16'd1000);
		push_beat(OP_ADVANCE, 32'd0, 16'd8000);
		push_beat(OP_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF);
		push_beat(OP_RESTART, 32'hFFFF_FC00, 16'd0);
		push_beat(OP_ADVANCE, 32'hFFFF_FFF0, 16'hFFF0);
		push_beat(OP_ADVANCE, 32'hFFFF_FFFF, 16'h000F);
		push_beat(OP_RESTART, 32'h1234_5678, 16'd1);
		push_beat(OP_ADVANCE, 32'h1234_5A60, 16'd1000);
		wait_idle();

		// all registers at the top but the low level, which is zero
		write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		write_reg(CFG_IDX_SPARE_LO, CFG_W'($urandom()));
		queue_blink_runs(3, 20000);
		wait_idle();

		// tiny half-period, no shrink, low above high
		write_settings(16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		write_reg(CFG_IDX_SPARE_HI, CFG_W'($urandom()));
		queue_blink_runs(3, 8);
		wait_idle();

		// zero half-period and zero floor, then a shrink step that overshoots the floor
		write_settings(16'd0, 16'd0, 16'hFFFF, 16'd1000, 16'd50000, 16'd128);
		queue_blink_runs(2, 4);
		wait_idle();
		write_reg(REG_START_INTERVAL, 16'd300);
		queue_blink_runs(2, 60);
		wait_idle();

		// zero coefficient, flat envelope; bursts without idling
		idle_pct = 0;
		write_settings(16'd500, 16'd30, 16'd70, 16'd0, 16'd0, 16'd0);
		queue_blink_runs(3, 200);
		wait_idle();
		idle_pct = 32;

		repeat (10) begin
			st = CFG_W'($urandom_range(20, 3000));
			lo = CFG_W'($urandom_range(40000));
			hi = CFG_W'($urandom_range(lo, 16'hFFFF));
			if ($urandom_range(5) == 0)
				{lo, hi} = {hi, lo};
			write_settings(st, CFG_W'($urandom_range(1, st)), CFG_W'($urandom_range(400)),
				lo, hi,
				($urandom_range(7) == 0) ? CFG_W'($urandom()) : CFG_W'($urandom_range(1023)));
			queue_blink_runs($urandom_range(3, 5), $urandom_range(1, st / 4 + 1));
			wait_idle();
		end

		repeat (END_WAIT) @(posedge clk);
		$display("covered %0d beats with %0d restarts and %0d direction switches,",
			beat_count, restarts, switches);
		$display("%0d register writes over %0d settings, %0d failures",
			reg_writes, settings, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
